// ===== rtl/core/ppcalu_pkg.sv =====
package ppcalu_pkg;

   // Architectural sizes.
   localparam int XlenWidth     = 64;
   localparam int CrWidth       = 32;
   localparam int RegIndexWidth = 5;
   localparam int RegCount      = 32;
   localparam int ImmWidth      = 16;

   // Decoded operation codes.
   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_ADDI   = 5'd1,
      OP_ADDIS  = 5'd2,
      OP_CMP    = 5'd3,
      OP_CMPI   = 5'd4,
      OP_CMPL   = 5'd5,
      OP_CMPLI  = 5'd6,
      OP_AND    = 5'd7,
      OP_ANDC   = 5'd8,
      OP_ANDI   = 5'd9,
      OP_ANDIS  = 5'd10,
      OP_CNTLZW = 5'd11,
      OP_EXTSB  = 5'd12,
      OP_NOR    = 5'd13,
      OP_OR     = 5'd14,
      OP_ORI    = 5'd15,
      OP_ORIS   = 5'd16,
      OP_XOR    = 5'd17,
      OP_XORI   = 5'd18,
      OP_XORIS  = 5'd19
   } opcode_type;

   // Condition register field codes; the summary-overflow bit is always clear.
   localparam logic [3:0] CR_LT = 4'h8;
   localparam logic [3:0] CR_GT = 4'h4;
   localparam logic [3:0] CR_EQ = 4'h2;

   // What the execution unit hands back for one instruction.
   typedef struct packed {
      logic [XlenWidth-1:0]     value;
      logic                     write;
      logic [RegIndexWidth-1:0] index;
      logic [CrWidth-1:0]       cr;
   } exec_result_type;

endpackage

// ===== rtl/core/ppcalu_regfile.sv =====
module ppcalu_regfile
   import ppcalu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [RegIndexWidth-1:0] wr_index,
   input  logic [XlenWidth-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [RegIndexWidth-1:0] rd_a_index,
   input  logic [RegIndexWidth-1:0] rd_b_index,
   output logic [XlenWidth-1:0]     rd_a_data,
   output logic [XlenWidth-1:0]     rd_b_data
);

   // Register storage and one valid bit per entry; an entry never written reads zero.
   logic [XlenWidth-1:0] mem_ff [RegCount];
   logic [RegCount-1:0]  valid_ff;
   logic [XlenWidth-1:0] rd_a_data_ff;
   logic [XlenWidth-1:0] rd_b_data_ff;
   logic                 rd_a_valid_ff;
   logic                 rd_b_valid_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_index] <= wr_data;
      end
   end

   // Valid bits are cleared together at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_index] <= 1'b1;
      end
   end

   // Two registered read ports. A write at the same edge passes straight
   // through, so a dependent instruction sees the value of the one before it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_index == rd_a_index)) begin
            rd_a_data_ff  <= wr_data;
            rd_a_valid_ff <= 1'b1;
         end else begin
            rd_a_data_ff  <= mem_ff[rd_a_index];
            rd_a_valid_ff <= valid_ff[rd_a_index];
         end
         if (wr_en && (wr_index == rd_b_index)) begin
            rd_b_data_ff  <= wr_data;
            rd_b_valid_ff <= 1'b1;
         end else begin
            rd_b_data_ff  <= mem_ff[rd_b_index];
            rd_b_valid_ff <= valid_ff[rd_b_index];
         end
      end
   end

   assign rd_a_data = rd_a_valid_ff ? rd_a_data_ff : '0;
   assign rd_b_data = rd_b_valid_ff ? rd_b_data_ff : '0;

endmodule

// ===== rtl/core/ppcalu_exec.sv =====
module ppcalu_exec
   import ppcalu_pkg::*;
(
   input  opcode_type               opcode,
   input  logic [RegIndexWidth-1:0] dest_index,
   input  logic                     a_is_zero,
   input  logic [XlenWidth-1:0]     a,
   input  logic [XlenWidth-1:0]     b,
   input  logic [ImmWidth-1:0]      imm,
   input  logic [CrWidth-1:0]       cr,
   output exec_result_type          result
);

   logic [XlenWidth-1:0] imm_s;
   logic [XlenWidth-1:0] imm_u;
   logic [XlenWidth-1:0] imm_s_hi;
   logic [XlenWidth-1:0] imm_u_hi;
   logic [XlenWidth-1:0] a_or_zero;
   logic [XlenWidth-1:0] a_sx;
   logic [XlenWidth-1:0] a_zx;
   logic [XlenWidth-1:0] b_sx;
   logic [XlenWidth-1:0] b_zx;
   logic                 wide;
   logic [XlenWidth-1:0] cmp_lhs;
   logic [XlenWidth-1:0] cmp_rhs;
   logic                 cmp_signed;
   logic [XlenWidth-1:0] cmp_l;
   logic [XlenWidth-1:0] cmp_r;
   logic [3:0]           cmp_code;
   logic [4:0]           cr_shift;
   logic [5:0]           lz_count;
   logic [XlenWidth-1:0] value;
   logic                 write;
   logic                 is_cmp;

   // Operand forms.
   assign imm_s     = {{(XlenWidth-ImmWidth){imm[ImmWidth-1]}}, imm};
   assign imm_u     = {{(XlenWidth-ImmWidth){1'b0}}, imm};
   assign imm_s_hi  = {{(XlenWidth-2*ImmWidth){imm[ImmWidth-1]}}, imm, {ImmWidth{1'b0}}};
   assign imm_u_hi  = {{(XlenWidth-2*ImmWidth){1'b0}}, imm, {ImmWidth{1'b0}}};
   assign a_or_zero = a_is_zero ? '0 : a;
   assign a_sx      = {{32{a[31]}}, a[31:0]};
   assign a_zx      = {32'b0, a[31:0]};
   assign b_sx      = {{32{b[31]}}, b[31:0]};
   assign b_zx      = {32'b0, b[31:0]};
   assign wide      = dest_index[0];

   // Compare operand selection by width and order.
   always_comb begin
      cmp_lhs    = wide ? a : a_sx;
      cmp_rhs    = wide ? b : b_sx;
      cmp_signed = 1'b1;
      unique case (opcode)
         OP_CMPI: begin
            cmp_rhs = imm_s;
         end
         OP_CMPL: begin
            cmp_lhs    = wide ? a : a_zx;
            cmp_rhs    = wide ? b : b_zx;
            cmp_signed = 1'b0;
         end
         OP_CMPLI: begin
            cmp_lhs    = wide ? a : a_zx;
            cmp_rhs    = imm_u;
            cmp_signed = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Signed order is unsigned order with the sign bits flipped.
   assign cmp_l = {cmp_lhs[XlenWidth-1] ^ cmp_signed, cmp_lhs[XlenWidth-2:0]};
   assign cmp_r = {cmp_rhs[XlenWidth-1] ^ cmp_signed, cmp_rhs[XlenWidth-2:0]};

   always_comb begin
      priority if (cmp_l < cmp_r) begin
         cmp_code = CR_LT;
      end else if (cmp_l > cmp_r) begin
         cmp_code = CR_GT;
      end else begin
         cmp_code = CR_EQ;
      end
   end

   // Field BF sits at bits 31-4*BF down to 28-4*BF.
   assign cr_shift = {~dest_index[4:2], 2'b00};

   // Leading zeros of the low word; the highest set bit wins, zero gives 32.
   always_comb begin
      lz_count = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (a[i]) begin
            lz_count = 6'(31 - i);
         end
      end
   end

   // Result selection.
   always_comb begin
      value  = '0;
      write  = 1'b1;
      is_cmp = 1'b0;
      unique case (opcode)
         OP_ADD:    value = a + b;
         OP_ADDI:   value = a_or_zero + imm_s;
         OP_ADDIS:  value = a_or_zero + imm_s_hi;
         OP_CMP, OP_CMPI, OP_CMPL, OP_CMPLI: begin
            write  = 1'b0;
            is_cmp = 1'b1;
         end
         OP_AND:    value = a & b;
         OP_ANDC:   value = a & ~b;
         OP_ANDI:   value = a & imm_u;
         OP_ANDIS:  value = a & imm_u_hi;
         OP_CNTLZW: value = {{(XlenWidth-6){1'b0}}, lz_count};
         OP_EXTSB:  value = {{(XlenWidth-8){a[7]}}, a[7:0]};
         OP_NOR:    value = ~(a | b);
         OP_OR:     value = a | b;
         OP_ORI:    value = a | imm_u;
         OP_ORIS:   value = a | imm_u_hi;
         OP_XOR:    value = a ^ b;
         OP_XORI:   value = a ^ imm_u;
         OP_XORIS:  value = a ^ imm_u_hi;
         default:   write = 1'b0;
      endcase
   end

   // Pack the outcome; nothing written reports zero value and index.
   always_comb begin
      result.value = write ? value : '0;
      result.write = write;
      result.index = write ? dest_index : '0;
      result.cr    = cr;
      if (is_cmp) begin
         result.cr = (cr & ~(CrWidth'(4'hF) << cr_shift))
                   | (CrWidth'(cmp_code) << cr_shift);
      end
   end

endmodule

// ===== rtl/core/powerpc_integer_alu_subset_unit.sv =====
// Channel | Direction | Ports                                   | Handshake
// req     | in        | opcode, dest/src indexes, immediate     | req_valid / req_stall
// rsp     | out       | result value, write flag, index, CR     | rsp_valid / rsp_stall
//
// One instruction enters per cycle while req_stall is low; its word passes through the
// operand stage, read from the register file at acceptance, and then the result register.
// A dependent instruction right behind gets its operand through the file's write bypass.
// Synchronous reset clears control, the condition register and the file valid bits.
// A stall on rsp holds the result register and then the operand stage, back to req_stall.
module powerpc_integer_alu_subset_unit
   import ppcalu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [4:0]               req_opcode,
   input  logic [RegIndexWidth-1:0] req_dest_index,
   input  logic [RegIndexWidth-1:0] req_src_a_index,
   input  logic [RegIndexWidth-1:0] req_src_b_index,
   input  logic [ImmWidth-1:0]      req_immediate,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [XlenWidth-1:0]     rsp_result_value,
   output logic                     rsp_wrote_register,
   output logic [RegIndexWidth-1:0] rsp_written_index,
   output logic [CrWidth-1:0]       rsp_condition_out
);

   logic                     accept;
   logic                     s1_move;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   opcode_type               s1_opcode_ff;
   logic [RegIndexWidth-1:0] s1_dest_ff;
   logic                     s1_a_zero_ff;
   logic [ImmWidth-1:0]      s1_imm_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   exec_result_type          out_ff;
   logic [CrWidth-1:0]       cr_ff;
   logic [XlenWidth-1:0]     op_a;
   logic [XlenWidth-1:0]     op_b;
   exec_result_type          exec_res;

   // Handshake: the operand stage advances when the result register is free or emptying.
   assign s1_move   = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;
   assign accept    = req_valid & ~req_stall;

   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_move);
   assign out_valid_in = s1_move | (out_valid_ff & rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cr_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            cr_ff <= exec_res.cr;
         end
      end
   end

   // Operand stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff <= opcode_type'(req_opcode);
         s1_dest_ff   <= req_dest_index;
         s1_a_zero_ff <= (req_src_a_index == '0);
         s1_imm_ff    <= req_immediate;
      end
   end

   // Register file: read on acceptance, written when the instruction retires.
   ppcalu_regfile u_regfile (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (s1_move & exec_res.write),
      .wr_index   (exec_res.index),
      .wr_data    (exec_res.value),
      .rd_en      (accept),
      .rd_a_index (req_src_a_index),
      .rd_b_index (req_src_b_index),
      .rd_a_data  (op_a),
      .rd_b_data  (op_b)
   );

   // Execution.
   ppcalu_exec u_exec (
      .opcode     (s1_opcode_ff),
      .dest_index (s1_dest_ff),
      .a_is_zero  (s1_a_zero_ff),
      .a          (op_a),
      .b          (op_b),
      .imm        (s1_imm_ff),
      .cr         (cr_ff),
      .result     (exec_res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= exec_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_ff.value;
   assign rsp_wrote_register = out_ff.write;
   assign rsp_written_index  = out_ff.index;
   assign rsp_condition_out  = out_ff.cr;

`ifndef ASSERT_OFF
   // The input side only stalls behind an instruction waiting in the operand stage.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> s1_valid_ff)
      else $error("req_stall without a waiting operand stage");

   // The condition register changes only when an instruction retires.
   assert property (@(posedge clock) disable iff (reset) !s1_move |=> $stable(cr_ff))
      else $error("condition register changed without a retiring instruction");

   // A result on offer always carries the current condition register.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_condition_out == cr_ff))
      else $error("result word condition differs from the condition register");

   // A word that writes no register reports zero value and index.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_wrote_register) |->
      (rsp_result_value == '0 && rsp_written_index == '0))
      else $error("non-writing word carries a value or index");
`endif

endmodule

// ===== test/tb.sv =====
module tb
   import ppcalu_pkg::*;
();

   // Shadow copy of the ALU state that predicts each result word and checks it on arrival.
   class alu_shadow;
      logic [XlenWidth-1:0] regs [RegCount];
      logic [CrWidth-1:0]   cr;
      exec_result_type      awaited_words [$];
      int                   mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         cr = '0;
         mismatches = 0;
      endfunction

      // Write LT, GT or EQ into condition field bf; the summary-overflow bit stays clear.
      function void compare_field(logic [63:0] lhs, logic [63:0] rhs, bit signed_order,
                                  logic [2:0] bf);
         logic [3:0] nib;
         int         sh;
         if (signed_order ? ($signed(lhs) < $signed(rhs)) : (lhs < rhs)) nib = CR_LT;
         else if (lhs == rhs) nib = CR_EQ;
         else nib = CR_GT;
         sh = 28 - 4 * bf;
         cr = (cr & ~(32'hF << sh)) | ({28'd0, nib} << sh);
      endfunction

      // Execute one accepted instruction and queue the word it must produce.
      function void note_instruction(opcode_type op, logic [4:0] d, logic [4:0] ia,
                                     logic [4:0] ib, logic [15:0] imm);
         logic [63:0]     a, b, s, u, a0, v;
         logic            wr;
         exec_result_type word;
         a  = regs[ia];
         b  = regs[ib];
         s  = {{48{imm[15]}}, imm};
         u  = {48'd0, imm};
         a0 = (ia == 0) ? 64'd0 : a;
         v  = '0;
         wr = 1'b1;
         case (op)
            OP_ADD:    v = a + b;
            OP_ADDI:   v = a0 + s;
            OP_ADDIS:  v = a0 + (s << 16);
            OP_CMP: begin
               wr = 1'b0;
               if (d[0]) compare_field(a, b, 1'b1, d[4:2]);
               else compare_field({{32{a[31]}}, a[31:0]}, {{32{b[31]}}, b[31:0]}, 1'b1,
                                  d[4:2]);
            end
            OP_CMPI: begin
               wr = 1'b0;
               compare_field(d[0] ? a : {{32{a[31]}}, a[31:0]}, s, 1'b1, d[4:2]);
            end
            OP_CMPL: begin
               wr = 1'b0;
               if (d[0]) compare_field(a, b, 1'b0, d[4:2]);
               else compare_field({32'd0, a[31:0]}, {32'd0, b[31:0]}, 1'b0, d[4:2]);
            end
            OP_CMPLI: begin
               wr = 1'b0;
               compare_field(d[0] ? a : {32'd0, a[31:0]}, u, 1'b0, d[4:2]);
            end
            OP_AND:    v = a & b;
            OP_ANDC:   v = a & ~b;
            OP_ANDI:   v = a & u;
            OP_ANDIS:  v = a & (u << 16);
            OP_CNTLZW: begin
               // The highest set bit of the low word wins; zero counts as 32.
               v = 64'd32;
               for (int i = 0; i < 32; i++) if (a[i]) v = 64'(31 - i);
            end
            OP_EXTSB:  v = {{56{a[7]}}, a[7:0]};
            OP_NOR:    v = ~(a | b);
            OP_OR:     v = a | b;
            OP_ORI:    v = a | u;
            OP_ORIS:   v = a | (u << 16);
            OP_XOR:    v = a ^ b;
            OP_XORI:   v = a ^ u;
            OP_XORIS:  v = a ^ (u << 16);
            default:   wr = 1'b0;
         endcase
         if (wr) regs[d] = v;
         word.value = wr ? v : 64'd0;
         word.write = wr;
         word.index = wr ? d : 5'd0;
         word.cr    = cr;
         awaited_words.insert(awaited_words.size(), word);
      endfunction

      function void report_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
         end
      endfunction

      // Compare an arriving word with the oldest prediction.
      function void check_word(exec_result_type got);
         exec_result_type want;
         if (awaited_words.size() == 0) begin
            mismatches++;
            $display("%0t: word expected none got %h", $time, got);
            return;
         end
         want = awaited_words.pop_front();
         report_field("result_value", want.value, got.value);
         report_field("wrote_register", 64'(want.write), 64'(got.write));
         report_field("written_index", 64'(want.index), 64'(got.index));
         report_field("condition_out", 64'(want.cr), 64'(got.cr));
      endfunction

      function int outstanding();
         return awaited_words.size();
      endfunction

      function void check_leftover();
         if (awaited_words.size() != 0) begin
            mismatches++;
            $display("%0t: words expected %0d more got none", $time, awaited_words.size());
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [4:0]               req_opcode = '0;
   logic [RegIndexWidth-1:0] req_dest_index = '0;
   logic [RegIndexWidth-1:0] req_src_a_index = '0;
   logic [RegIndexWidth-1:0] req_src_b_index = '0;
   logic [ImmWidth-1:0]      req_immediate = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [XlenWidth-1:0]     rsp_result_value;
   logic                     rsp_wrote_register;
   logic [RegIndexWidth-1:0] rsp_written_index;
   logic [CrWidth-1:0]       rsp_condition_out;

   alu_shadow shadow = new();

   // Idle controls for the stimulus and the receiver.
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   bit hold_request = 1'b0;
   int tx_gap = 0;
   bit tx_held = 1'b0;

   powerpc_integer_alu_subset_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_dest_index     (req_dest_index),
      .req_src_a_index    (req_src_a_index),
      .req_src_b_index    (req_src_b_index),
      .req_immediate      (req_immediate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_wrote_register (rsp_wrote_register),
      .rsp_written_index  (rsp_written_index),
      .rsp_condition_out  (rsp_condition_out)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one instruction word after the drawn gap and hold it until it is taken.
   task automatic issue(opcode_type op, logic [4:0] d, logic [4:0] ia, logic [4:0] ib,
                        logic [15:0] imm);
      if (tx_gap > 0) repeat (tx_gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_dest_index  <= d;
      req_src_a_index <= ia;
      req_src_b_index <= ib;
      req_immediate   <= imm;
      do @(posedge clock); while (req_stall);
      shadow.note_instruction(op, d, ia, ib, imm);
      // Valid stays up only when the next word follows with no gap.
      tx_gap  = tx_idle ? $urandom_range(0, 13) : 0;
      tx_held = (tx_gap == 0);
      if (!tx_held) req_valid <= 1'b0;
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain_words();
      if (tx_held) begin
         req_valid <= 1'b0;
         tx_held = 1'b0;
      end
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // Mostly a few low registers, so that back-to-back dependencies are common.
   function automatic logic [4:0] pick_reg();
      return $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Receiver: stalls a drawn number of cycles before each word, once for a long stretch.
   initial begin : receiver
      int gap;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap = 160;
         end else begin
            gap = rx_idle ? $urandom_range(0, 13) : 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Every word taken from the block is checked against the shadow.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_word({rsp_result_value, rsp_wrote_register, rsp_written_index,
                            rsp_condition_out});
   end

   initial begin
      #(12 * 300000);
      $display("tb: errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, every operation and the special cases.
      issue(OP_ADDI, 1, 0, 0, 16'h7FFF);    // source zero reads as the value zero
      issue(OP_ADDI, 2, 0, 0, 16'h8000);
      issue(OP_ADDIS, 3, 0, 0, 16'h8000);
      issue(OP_NOR, 5, 0, 0, 16'h0000);
      issue(OP_ADD, 6, 5, 5, 16'h0000);     // sum wraps
      issue(OP_ORI, 7, 0, 0, 16'hFFFF);
      issue(OP_ORIS, 8, 7, 0, 16'hFFFF);
      issue(OP_AND, 9, 5, 3, 16'h0000);
      issue(OP_ANDC, 10, 5, 3, 16'h0000);
      issue(OP_ANDI, 11, 5, 0, 16'hFFFF);
      issue(OP_ANDIS, 12, 5, 0, 16'hFFFF);
      issue(OP_CNTLZW, 13, 0, 0, 16'h0000); // zero input counts 32
      issue(OP_CNTLZW, 14, 5, 0, 16'h0000);
      issue(OP_ORI, 16, 0, 0, 16'h0080);
      issue(OP_EXTSB, 17, 16, 0, 16'h0000);
      issue(OP_EXTSB, 18, 13, 0, 16'h0000);
      issue(OP_XOR, 19, 5, 1, 16'h0000);
      issue(OP_XORI, 20, 5, 0, 16'hFFFF);
      issue(OP_XORIS, 21, 5, 0, 16'hFFFF);
      issue(OP_OR, 22, 1, 3, 16'h0000);
      issue(OP_CMP, 0, 3, 1, 16'h0000);
      issue(OP_CMP, 29, 1, 1, 16'h0000);
      issue(OP_CMPI, 5, 3, 0, 16'h8000);
      issue(OP_CMPL, 10, 3, 1, 16'h0000);
      issue(OP_CMPLI, 31, 5, 0, 16'hFFFF);
      issue(OP_ORI, 0, 5, 0, 16'h0001);     // register zero now holds all ones
      issue(OP_ADDI, 23, 0, 0, 16'h0001);
      issue(OP_ADD, 24, 0, 0, 16'h0000);
      drain_words();

      // Random phases with changing idle patterns; the third holds the receiver off.
      for (int phase = 0; phase < 7; phase++) begin
         tx_idle = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         rx_idle = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         if (phase == 2) begin
            hold_request = 1'b1;
            tx_idle = 1'b0;
         end
         repeat (200)
            issue(opcode_type'($urandom_range(0, 19)), pick_reg(), pick_reg(), pick_reg(),
                  pick_imm());
         drain_words();
      end

      repeat (8) @(posedge clock);
      shadow.check_leftover();
      if (shadow.mismatches == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
